// File: hw/rtl/rank_normalizer_assert.svh
// Assertion helpers for the rank normalizer checker.
`ifndef RANK_NORMALIZER_ASSERT_SVH
`define RANK_NORMALIZER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define RN_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rank_normalizer check failed");

// Next-cycle implication, disabled during reset.
`define RN_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rank_normalizer check failed");

`endif

// File: hw/rtl/rn_pkg.sv
`timescale 1ns / 1ps

package rn_pkg;

  localparam int MAX_ITEMS  = 64;
  localparam int VALUE_BITS = 32;

  localparam int SAMPLE_W   = 32;
  localparam int RANK_W     = 6;
  localparam int CNT_BITS   = $clog2(MAX_ITEMS);
  localparam int IDX_BITS   = $clog2(MAX_ITEMS);
  localparam int COUNT_BITS = $clog2(MAX_ITEMS + 1);

  typedef logic signed [VALUE_BITS-1:0] value_t;

  // Per-cycle command broadcast to every cell.
  typedef struct packed {
    logic load;    // store the incoming sample in the first free cell
    logic start;   // copy own value into the circulating slot, clear count
    logic step;    // compare against passing value, then rotate the ring
    logic drain;   // take the count of the neighbouring cell k+1; counts shift toward cell 0
  } cell_ctrl_t;

  // Truncate or sign extend a sample to the stored width.
  function automatic value_t to_value(input logic signed [SAMPLE_W-1:0] s);
    return value_t'(s);
  endfunction

endpackage

// File: hw/rtl/rn_cell.sv
`timescale 1ns / 1ps

module rn_cell import rn_pkg::*; (
  input  logic                clk,
  input  cell_ctrl_t          ctrl,
  input  logic                occupied,
  input  logic                load_here,
  input  value_t              sample_in,
  input  value_t              circ_in,
  input  logic                circ_valid_in,
  input  logic [CNT_BITS-1:0] count_in,
  output value_t              circ_out,
  output logic                circ_valid_out,
  output logic [CNT_BITS-1:0] count_out
);

  value_t              value;
  value_t              circ;
  logic                circ_valid;
  logic [CNT_BITS-1:0] count;

  always_ff @(posedge clk) begin
    if (ctrl.load && load_here) begin
      value <= sample_in;
    end
    if (ctrl.start) begin
      circ       <= value;
      circ_valid <= occupied;
      count      <= '0;
    end else if (ctrl.step) begin
      if (circ_valid && (circ < value)) begin
        count <= count + CNT_BITS'(1);
      end
      circ       <= circ_in;
      circ_valid <= circ_valid_in;
    end else if (ctrl.drain) begin
      count <= count_in;
    end
  end

  assign circ_out       = circ;
  assign circ_valid_out = circ_valid;
  assign count_out      = count;

endmodule

// File: hw/rtl/rank_normalizer.sv
`timescale 1ns / 1ps
// Rank normalizer: replaces each value of a set by its rank (number of set
// members strictly smaller), equal values sharing the lowest rank.
// Input channel: sample_value / final_value on sample_valid / sample_ready.
//   One request per cycle is taken while a set is loading; up to MAX_ITEMS
//   values are kept, later ones are dropped and flag the set as truncated.
// Output channel: rank / last_rank / truncated on rank_valid / rank_ready,
//   one result per stored value in arrival order, last_rank on the final.
// Sequence: the request with final_value set closes the set. Ranking then
//   copies each value into the ring (S_START), rotates the ring of cells
//   once completely (S_COMPARE), and S_PRESENT registers the first result.
//   Results follow at one per cycle while rank_ready is high.
// Input is not taken while ranking or emitting. A stalled receiver simply
//   holds the current result; nothing is lost.
// Reset (rst, synchronous) empties the set and clears the overflow flag
//   and any pending result.
module rank_normalizer import rn_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       sample_valid,
  output logic                       sample_ready,
  input  logic signed [SAMPLE_W-1:0] sample_value,
  input  logic                       final_value,
  output logic                       rank_valid,
  input  logic                       rank_ready,
  output logic [RANK_W-1:0]          rank,
  output logic                       last_rank,
  output logic                       truncated
);

  typedef enum logic [2:0] {
    S_LOAD,
    S_START,
    S_COMPARE,
    S_PRESENT,
    S_EMIT
  } state_t;

  localparam logic [IDX_BITS-1:0]   STEP_LAST = IDX_BITS'(MAX_ITEMS - 1);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = COUNT_BITS'(MAX_ITEMS);

  state_t                state;
  logic [COUNT_BITS-1:0] count;
  logic                  overflow;
  logic [IDX_BITS-1:0]   step;
  logic [IDX_BITS-1:0]   emit_idx;
  cell_ctrl_t            ctrl;

  value_t              circ_chain  [MAX_ITEMS];
  logic                circv_chain [MAX_ITEMS];
  logic [CNT_BITS-1:0] rank_of     [MAX_ITEMS];

  value_t              sample_cut;
  logic                sample_take;
  logic                result_take;
  logic [IDX_BITS-1:0] first_idx;
  logic [IDX_BITS-1:0] next_idx;

  assign sample_ready = (state == S_LOAD);
  assign sample_take  = sample_valid && sample_ready;
  assign result_take  = rank_valid && rank_ready;
  assign sample_cut   = to_value(sample_value);
  assign first_idx    = IDX_BITS'(count - COUNT_BITS'(1));
  assign next_idx     = emit_idx - IDX_BITS'(1);

  always_comb begin
    ctrl       = '0;
    ctrl.load  = sample_take && (count < COUNT_MAX);
    ctrl.start = (state == S_START);
    ctrl.step  = (state == S_COMPARE);
    ctrl.drain = result_take;
  end

  for (genvar k = 0; k < MAX_ITEMS; k++) begin : g_cell
    value_t              prev_circ;
    logic                prev_circv;
    logic [CNT_BITS-1:0] next_rank;
    logic                occupied;
    logic                load_here;

    if (k == 0) begin : g_head
      assign prev_circ  = circ_chain[MAX_ITEMS-1];
      assign prev_circv = circv_chain[MAX_ITEMS-1];
    end else begin : g_body
      assign prev_circ  = circ_chain[k-1];
      assign prev_circv = circv_chain[k-1];
    end

    if (k == MAX_ITEMS - 1) begin : g_tail
      assign next_rank = '0;
    end else begin : g_inner
      assign next_rank = rank_of[k+1];
    end

    assign occupied  = (COUNT_BITS'(k) < count);
    assign load_here = (COUNT_BITS'(k) == count);

    rn_cell u_cell (
      .clk            (clk),
      .ctrl           (ctrl),
      .occupied       (occupied),
      .load_here      (load_here),
      .sample_in      (sample_cut),
      .circ_in        (prev_circ),
      .circ_valid_in  (prev_circv),
      .count_in       (next_rank),
      .circ_out       (circ_chain[k]),
      .circ_valid_out (circv_chain[k]),
      .count_out      (rank_of[k])
    );
  end

  // Cells fill in arrival order; ranks drain toward cell 0 as results go out.
  // emit_idx counts the results still to follow the current one.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_LOAD;
      count      <= '0;
      overflow   <= 1'b0;
      step       <= '0;
      emit_idx   <= '0;
      rank_valid <= 1'b0;
    end else begin
      case (state)
        S_LOAD: begin
          if (sample_take) begin
            if (count < COUNT_MAX) begin
              count <= count + COUNT_BITS'(1);
            end else begin
              overflow <= 1'b1;
            end
            if (final_value) begin
              state <= S_START;
            end
          end
        end
        S_START: begin
          step  <= '0;
          state <= S_COMPARE;
        end
        S_COMPARE: begin
          step <= step + IDX_BITS'(1);
          if (step == STEP_LAST) begin
            state <= S_PRESENT;
          end
        end
        S_PRESENT: begin
          emit_idx   <= first_idx;
          rank       <= RANK_W'(rank_of[0]);
          last_rank  <= (first_idx == '0);
          truncated  <= overflow;
          rank_valid <= 1'b1;
          state      <= S_EMIT;
        end
        S_EMIT: begin
          if (result_take) begin
            if (emit_idx == '0) begin
              rank_valid <= 1'b0;
              count      <= '0;
              overflow   <= 1'b0;
              state      <= S_LOAD;
            end else begin
              emit_idx  <= next_idx;
              rank      <= RANK_W'(rank_of[1]);
              last_rank <= (next_idx == '0);
            end
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

endmodule

// File: hw/rtl/rn_checker.sv
`timescale 1ns / 1ps
`include "rank_normalizer_assert.svh"

module rn_checker import rn_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              sample_ready,
  input logic              rank_valid,
  input logic              rank_ready,
  input logic [RANK_W-1:0] rank,
  input logic              last_rank,
  input logic              truncated
);

  localparam logic [RANK_W-1:0] RANK_TOP = RANK_W'(MAX_ITEMS - 1);

  // No new request is taken while results of a set are pending.
  `RN_ASSERT_NOW(a_no_load_while_emit, rank_valid, !sample_ready)

  // A rank never reaches the set capacity.
  `RN_ASSERT_NOW(a_rank_in_range, rank_valid, rank <= RANK_TOP)

  // After the last result the block is back to loading.
  `RN_ASSERT_NEXT(a_back_to_load, rank_valid && rank_ready && last_rank,
                  !rank_valid && sample_ready)

  // A stalled result holds.
  `RN_ASSERT_NEXT(a_stall_hold, rank_valid && !rank_ready,
                  rank_valid && $stable(rank) && $stable(last_rank) && $stable(truncated))

endmodule

bind rank_normalizer rn_checker u_rn_checker (.*);

// File: tb/rank_normalizer_test.sv
`timescale 1ns / 1ps

module rank_normalizer_test import rn_pkg::*;;

  localparam int IDLE_LIMIT   = 4000;
  localparam int RANDOM_ITEMS = 120;

  typedef struct packed {
    logic [RANK_W-1:0] rank;
    logic              is_last;
    logic              dropped;
  } rank_result_t;

  typedef enum logic [1:0] {
    RDY_ALWAYS,
    RDY_COIN,
    RDY_MOSTLY,
    RDY_PERIODIC
  } ready_mode_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       sample_valid = 1'b0;
  logic                       sample_ready;
  logic signed [SAMPLE_W-1:0] sample_value = '0;
  logic                       final_value = 1'b0;
  logic                       rank_valid;
  logic                       rank_ready = 1'b0;
  logic [RANK_W-1:0]          rank;
  logic                       last_rank;
  logic                       truncated;

  rank_normalizer u_dut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample_value (sample_value),
    .final_value  (final_value),
    .rank_valid   (rank_valid),
    .rank_ready   (rank_ready),
    .rank         (rank),
    .last_rank    (last_rank),
    .truncated    (truncated)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Predictor state: the open set as the block should hold it.
  value_t       set_values [MAX_ITEMS];
  int           set_count = 0;
  logic         set_overflow = 1'b0;
  rank_result_t pending_ranks [$];

  int error_count = 0;
  int idle_cycles = 0;
  int burst_left  = 0;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t ns: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    error_count++;
  endtask

  // Stores a value or flags overflow; on the closing one works out every rank.
  task automatic predict_ranks(input logic signed [SAMPLE_W-1:0] value_bits,
                               input logic closes_set);
    rank_result_t res;
    int           smaller;
    if (set_count < MAX_ITEMS) begin
      set_values[set_count] = value_t'(value_bits);
      set_count++;
    end else begin
      set_overflow = 1'b1;
    end
    if (closes_set) begin
      for (int i = 0; i < set_count; i++) begin
        smaller = 0;
        for (int j = 0; j < set_count; j++)
          if (set_values[j] < set_values[i]) smaller++;
        res.rank    = smaller[RANK_W-1:0];
        res.is_last = (i == set_count - 1);
        res.dropped = set_overflow;
        pending_ranks.push_back(res);
      end
      set_count    = 0;
      set_overflow = 1'b0;
    end
  endtask

  // Sends one request; inputs move on the falling edge only.
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] value_bits,
                             input logic closes_set);
    if (burst_left == 0) begin
      sample_valid = 1'b0;
      if ($urandom_range(0, 3) != 0)
        repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = $urandom_range(1, 24);
    end
    sample_valid = 1'b1;
    sample_value = value_bits;
    final_value  = closes_set;
    do @(posedge clk); while (!sample_ready);
    predict_ranks(value_bits, closes_set);
    @(negedge clk);
    sample_valid = 1'b0;
    burst_left--;
  endtask

  function automatic logic signed [SAMPLE_W-1:0] pick_value();
    case ($urandom_range(0, 5))
      0:       return 32'h8000_0000 + $urandom_range(0, 2);
      1:       return 32'h7fff_ffff - $urandom_range(0, 2);
      2, 3:    return int'($urandom_range(0, 6)) - 3;  // many ties
      default: return $urandom;
    endcase
  endfunction

  task automatic send_random_set(input int size);
    for (int i = 0; i < size; i++)
      send_sample(pick_value(), i == size - 1);
  endtask

  task automatic drain_ranks();
    while (pending_ranks.size() != 0) @(posedge clk);
  endtask

  task automatic test_single_value();
    send_sample(32'h1234_5678, 1'b1);
  endtask

  task automatic test_extremes();
    send_sample(32'h7fff_ffff, 1'b0);
    send_sample(32'h8000_0000, 1'b0);
    send_sample(32'h0000_0000, 1'b0);
    send_sample(32'hffff_ffff, 1'b0);
    send_sample(32'h0000_0001, 1'b0);
    send_sample(32'h8000_0000, 1'b0);
    send_sample(32'h7fff_ffff, 1'b1);
  endtask

  task automatic test_all_equal();
    for (int i = 0; i < 4; i++)
      send_sample(32'hdead_beef, i == 3);
  endtask

  task automatic test_descending();
    for (int i = 0; i < 5; i++)
      send_sample(32'sd100 - 40 * i, i == 4);
  endtask

  task automatic test_full_store();
    send_random_set(MAX_ITEMS);
  endtask

  // Store fills, one more value is dropped, then the closing value is dropped too.
  task automatic test_overflow();
    for (int i = 0; i < MAX_ITEMS + 2; i++)
      send_sample($urandom, i == MAX_ITEMS + 1);
  endtask

  task automatic test_random_sets();
    int sent;
    int size;
    bool_pause_done: begin end
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      size = ($urandom_range(0, 14) == 0) ? $urandom_range(MAX_ITEMS - 4, MAX_ITEMS + 4)
                                          : $urandom_range(1, 10);
      send_random_set(size);
      sent += size;
      // hold off once until the block has emitted everything
      if (sent >= RANDOM_ITEMS / 2 && sent - size < RANDOM_ITEMS / 2) begin
        drain_ranks();
        repeat ($urandom_range(2, 10)) @(negedge clk);
      end
    end
  endtask

  // Receiver stalls on its own schedule, switching style now and then.
  ready_mode_t ready_mode = RDY_ALWAYS;
  int          mode_left  = 0;

  always @(negedge clk) begin
    if (mode_left == 0) begin
      ready_mode = ready_mode_t'($urandom_range(0, 3));
      mode_left  = $urandom_range(8, 60);
    end else begin
      mode_left--;
    end
    case (ready_mode)
      RDY_ALWAYS: rank_ready <= 1'b1;
      RDY_COIN:   rank_ready <= ($urandom_range(0, 1) == 1);
      RDY_MOSTLY: rank_ready <= ($urandom_range(0, 7) != 0);
      default:    rank_ready <= ((mode_left % 9) < 3);
    endcase
  end

  always @(posedge clk) begin : check_ranks
    rank_result_t want;
    if (!rst && rank_valid && rank_ready) begin
      if (pending_ranks.size() == 0) begin
        report_mismatch("results pending at arrival", 0, 1);
      end else begin
        want = pending_ranks.pop_front();
        if (rank !== want.rank) report_mismatch("rank", rank, want.rank);
        if (last_rank !== want.is_last) report_mismatch("last_rank", last_rank, want.is_last);
        if (truncated !== want.dropped) report_mismatch("truncated", truncated, want.dropped);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (sample_valid && sample_ready) || (rank_valid && rank_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout after %0d idle cycles", idle_cycles);
      $display("rank_normalizer_test NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (8) @(negedge clk);
    rst = 1'b0;
    test_single_value();
    test_extremes();
    test_all_equal();
    test_descending();
    test_full_store();
    test_overflow();
    test_random_sets();
    drain_ranks();
    repeat (MAX_ITEMS + 8) @(posedge clk);
    if (pending_ranks.size() != 0)
      report_mismatch("results still pending", pending_ranks.size(), 0);
    if (error_count == 0)
      $display("rank_normalizer_test OK");
    else
      $display("rank_normalizer_test NOT OK");
    $finish;
  end

endmodule
